@@ rtl/core/escaped_frame_receiver_crc16_assert.svh @@
// Assertion macros shared by the deframer checkers.
`ifndef ESCAPED_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_CRC16_ASSERT_SVH

// Check a property at each rising clock edge, skipped while reset is high.
`define EFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define EFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/efr_pkg.sv @@
// Types, constants and the CRC function of the escaped frame receiver.
`timescale 1ns / 1ps

package efr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned IDX_W  = 9;
   localparam int unsigned CRC_W  = 16;

   localparam logic [BYTE_W-1:0] FRAME_START   = 8'hC0;
   localparam logic [BYTE_W-1:0] FRAME_ESC     = 8'hDB;
   localparam logic [BYTE_W-1:0] ESC_FOR_START = 8'hDC;
   localparam logic [BYTE_W-1:0] ESC_FOR_ESC   = 8'hDD;
   localparam logic [IDX_W-1:0]  LEN_POS       = 9'd7;
   localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;

   typedef enum logic [1:0] {
      MODE_WAIT    = 2'd0,
      MODE_HEADER  = 2'd1,
      MODE_PAYLOAD = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_MSG         = 2'd0,
      KIND_START_ABORT = 2'd1,
      KIND_ESC_ABORT   = 2'd2
   } kind_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic [IDX_W-1:0]  index;
      logic              last;
      logic              crc_ok;
   } result_type;

   // One byte of CRC-16/XMODEM, MSB first.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/core/efr_channels.sv @@
// Valid/ready channel interfaces for received bytes and decoded items.
`timescale 1ns / 1ps

interface efr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] data_byte;
   logic [8:0] byte_index;
   logic       last_byte;
   logic       crc_ok;

   modport source (output valid, output result_kind, output data_byte,
                   output byte_index, output last_byte, output crc_ok, input ready);
   modport sink   (input valid, input result_kind, input data_byte,
                   input byte_index, input last_byte, input crc_ok, output ready);
endinterface

@@ rtl/core/efr_deframer.sv @@
// Frame state, escape decode and running CRC; one byte per advance.
`timescale 1ns / 1ps

module efr_deframer #(
   parameter int unsigned HEADER_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            rx_byte,
   output efr_pkg::result_type   result
);
   import efr_pkg::*;

   mode_type          mode_ff, mode_in;
   logic              esc_ff, esc_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [CRC_W-1:0]  exp_crc_ff, exp_crc_in;
   logic [CRC_W-1:0]  run_crc_ff, run_crc_in;

   logic [BYTE_W-1:0] dec_byte;
   logic              have_byte;
   logic              bad_esc;
   logic [IDX_W-1:0]  idx;
   logic [CRC_W-1:0]  crc_next;
   logic [IDX_W:0]    pay_limit;

   localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HEADER_BYTES - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_WAIT;
         esc_ff     <= 1'b0;
         count_ff   <= '0;
         len_ff     <= '0;
         exp_crc_ff <= '0;
         run_crc_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         esc_ff     <= esc_in;
         count_ff   <= count_in;
         len_ff     <= len_in;
         exp_crc_ff <= exp_crc_in;
         run_crc_ff <= run_crc_in;
      end
   end

   // Escape decode of the current byte.
   always_comb begin
      dec_byte  = rx_byte;
      have_byte = 1'b0;
      bad_esc   = 1'b0;
      if (esc_ff) begin
         if (rx_byte == ESC_FOR_START) begin
            dec_byte  = FRAME_START;
            have_byte = 1'b1;
         end else if (rx_byte == ESC_FOR_ESC) begin
            dec_byte  = FRAME_ESC;
            have_byte = 1'b1;
         end else begin
            bad_esc = 1'b1;
         end
      end else if (rx_byte != FRAME_ESC) begin
         have_byte = 1'b1;
      end
   end

   assign idx       = count_ff - IDX_W'(2);
   assign crc_next  = crc_byte(run_crc_ff, dec_byte);
   assign pay_limit = (IDX_W+1)'(HEADER_BYTES) + {2'b00, len_ff} - (IDX_W+1)'(1);

   always_comb begin
      mode_in    = mode_ff;
      esc_in     = esc_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      exp_crc_in = exp_crc_ff;
      run_crc_in = run_crc_ff;
      result     = '0;
      result.kind = KIND_MSG;

      if (advance) begin
         case (mode_ff)
            MODE_HEADER, MODE_PAYLOAD: begin
               if (rx_byte == FRAME_START) begin
                  // restart the frame
                  mode_in      = MODE_HEADER;
                  esc_in       = 1'b0;
                  count_in     = '0;
                  len_in       = '0;
                  exp_crc_in   = '0;
                  run_crc_in   = '0;
                  result.valid = 1'b1;
                  result.kind  = KIND_START_ABORT;
               end else if (bad_esc) begin
                  esc_in       = 1'b0;
                  mode_in      = MODE_WAIT;
                  result.valid = 1'b1;
                  result.kind  = KIND_ESC_ABORT;
               end else if (!have_byte) begin
                  esc_in = 1'b1;
               end else begin
                  esc_in = 1'b0;
                  if (count_ff < IDX_W'(2)) begin
                     if (count_ff == '0) begin
                        exp_crc_in = {dec_byte, 8'h00};
                     end else begin
                        exp_crc_in = {exp_crc_ff[15:8], dec_byte};
                     end
                     count_in = count_ff + IDX_W'(1);
                  end else begin
                     count_in     = count_ff + IDX_W'(1);
                     run_crc_in   = crc_next;
                     result.valid = 1'b1;
                     result.data  = dec_byte;
                     result.index = idx;
                     if (mode_ff == MODE_HEADER) begin
                        if (idx == LEN_POS) begin
                           len_in = dec_byte;
                        end
                        if (idx >= HDR_LAST) begin
                           if (len_in == '0) begin
                              result.last = 1'b1;
                           end else begin
                              mode_in = MODE_PAYLOAD;
                           end
                        end
                     end else if ({1'b0, idx} >= pay_limit) begin
                        result.last = 1'b1;
                     end
                     if (result.last) begin
                        mode_in       = MODE_WAIT;
                        result.crc_ok = (crc_next == exp_crc_ff);
                     end
                  end
               end
            end
            default: begin
               // waiting: drop everything but a start
               mode_in = MODE_WAIT;
               if (rx_byte == FRAME_START) begin
                  mode_in    = MODE_HEADER;
                  esc_in     = 1'b0;
                  count_in   = '0;
                  len_in     = '0;
                  exp_crc_in = '0;
                  run_crc_in = '0;
               end
            end
         endcase
      end
   end

endmodule

@@ rtl/core/escaped_frame_receiver_crc16.sv @@
// Top level of the escaped frame receiver with CRC-16/XMODEM check.
`timescale 1ns / 1ps
// An accepted byte moves from the input register through the deframer into the result register.
// Throughput: one item per cycle while the result slot is free or emptying; the combinational decode
//   and byte-wise CRC update in efr_deframer close the state loop each cycle.
// Items that give no result (idle noise, escapes, CRC bytes) still wait for a free result slot.
// Reset (synchronous, active high) returns to waiting for a frame start and
//   empties the input and result registers.

module escaped_frame_receiver_crc16 #(
   parameter int unsigned HEADER_BYTES = 8
) (
   input  logic      clock,
   input  logic      reset,
   efr_req_if.sink   req_ch,
   efr_rsp_if.source rsp_ch
);
   import efr_pkg::*;

   // Input register: holds one received byte waiting for the deframer.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;

   // Result register: holds one decoded item until the sink takes it.
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;

   logic              req_take;
   logic              advance;
   result_type        result;

   // Advance the byte into the deframer when the result slot is free or
   // emptying this cycle. A byte that gives no result advances the same way.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);

   // Take a new byte whenever the input register is empty or moving on.
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   efr_deframer #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_deframer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = result.valid;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.result_kind = out_ff.kind;
   assign rsp_ch.data_byte   = out_ff.data;
   assign rsp_ch.byte_index  = out_ff.index;
   assign rsp_ch.last_byte   = out_ff.last;
   assign rsp_ch.crc_ok      = out_ff.crc_ok;

endmodule

@@ rtl/core/efr_checker.sv @@
// Port-level checker for the escaped frame receiver, bound to the top level.
`timescale 1ns / 1ps
`include "escaped_frame_receiver_crc16_assert.svh"

module efr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] result_kind,
   input logic [7:0] data_byte,
   input logic [8:0] byte_index,
   input logic       last_byte,
   input logic       crc_ok
);
   import efr_pkg::*;

   `EFR_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, $past(reset) |-> !rsp_valid, "item right after reset")
   `EFR_ASSERT(a_kind_legal, clock, reset, rsp_valid |-> (result_kind == KIND_MSG || result_kind == KIND_START_ABORT || result_kind == KIND_ESC_ABORT), "undefined item kind")
   `EFR_ASSERT(a_abort_clean, clock, reset, (rsp_valid && result_kind != KIND_MSG) |-> (data_byte == 8'd0 && byte_index == 9'd0 && !last_byte && !crc_ok), "abort item carries data")
   `EFR_ASSERT(a_crc_only_last, clock, reset, (rsp_valid && !last_byte) |-> !crc_ok, "crc_ok without last byte")
   `EFR_ASSERT(a_stall_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(result_kind) && $stable(data_byte) && $stable(byte_index) && $stable(last_byte) && $stable(crc_ok)), "stalled item changed")

endmodule

bind escaped_frame_receiver_crc16 efr_checker u_efr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .result_kind (rsp_ch.result_kind),
   .data_byte   (rsp_ch.data_byte),
   .byte_index  (rsp_ch.byte_index),
   .last_byte   (rsp_ch.last_byte),
   .crc_ok      (rsp_ch.crc_ok)
);

@@ dv/tb_top.sv @@
// Self-checking testbench of the escaped frame receiver against a byte-level predictor.
`timescale 1ns / 1ps

module tb_top;
   import efr_pkg::*;

   localparam int unsigned HDR_BYTES    = 8;
   localparam int unsigned LONG_HOLD    = 400;   // receiver hold-off that backs up the block
   localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no item moving on either side
   localparam int unsigned DRAIN_CYCLES = 8;     // settling margin after the last expected item

   // What the stream builder appends after a cut-off frame body.
   typedef enum int {
      TAIL_NONE,      // nothing; the next start byte aborts the frame
      TAIL_BAD_ESC,   // escape followed by a byte that is not a valid escape code
      TAIL_OPEN_ESC   // escape left pending; the next start byte must clear it
   } tail_kind_type;

   // One decoded item as the result channel carries it.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [8:0] index;
      logic       last;
      logic       crc_ok;
   } decoded_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   efr_req_if req_ch();
   efr_rsp_if rsp_ch();

   // Drive every block input from a variable with a known start value.
   logic       drv_valid  = 1'b0;
   logic [7:0] drv_byte   = 8'h00;
   logic       sink_ready = 1'b0;

   assign req_ch.valid   = drv_valid;
   assign req_ch.rx_byte = drv_byte;
   assign rsp_ch.ready   = sink_ready;

   escaped_frame_receiver_crc16 #(
      .HEADER_BYTES(HDR_BYTES)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #10 clock = ~clock;

   // Line bytes still to be offered, and decoded items still to arrive.
   logic [7:0]  line_q[$];
   decoded_type decoded_q[$];

   // Deframer state mirrored by the predictor.
   mode_type    rx_mode   = MODE_WAIT;
   logic        esc_armed = 1'b0;
   int unsigned body_cnt  = 0;      // decoded bytes of the frame, CRC bytes included
   logic [7:0]  pay_len   = 8'h00;
   logic [15:0] rx_crc    = 16'h0000;
   logic [15:0] calc_crc  = 16'h0000;

   // Stimulus pacing, set by the sequence below.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_arm      = 1'b0;

   // Owned by the receiver process.
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   // Owned by the monitor.
   bit          req_taken    = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatch_cnt = 0;

   // CRC-16/XMODEM, one bit at a time, MSB of the byte first.
   function automatic logic [15:0] crc16_xmodem_byte(input logic [15:0] crc,
                                                     input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // Clear the per-frame state on a start byte.
   task automatic open_frame();
      rx_mode   = MODE_HEADER;
      esc_armed = 1'b0;
      body_cnt  = 0;
      pay_len   = 8'h00;
      rx_crc    = 16'h0000;
      calc_crc  = 16'h0000;
   endtask

   // Advance the mirrored deframer by one accepted line byte and queue what it yields.
   task automatic deframe_byte(input logic [7:0] b);
      logic [7:0]  d;
      int unsigned idx;
      logic        fin;
      // Waiting for start: drop noise, open a frame on a start byte.
      if (rx_mode != MODE_HEADER && rx_mode != MODE_PAYLOAD) begin
         rx_mode = MODE_WAIT;
         if (b == FRAME_START) begin
            open_frame();
         end
         return;
      end
      // Start byte inside a frame: report the abort and restart, pending escape cleared.
      if (b == FRAME_START) begin
         open_frame();
         decoded_q.push_back('{kind: KIND_START_ABORT, data: 8'h00, index: 9'd0,
                               last: 1'b0, crc_ok: 1'b0});
         return;
      end
      if (esc_armed) begin
         esc_armed = 1'b0;
         if (b == ESC_FOR_START) begin
            d = FRAME_START;
         end else if (b == ESC_FOR_ESC) begin
            d = FRAME_ESC;
         end else begin
            // Bad escape code: report it and fall back to waiting.
            rx_mode = MODE_WAIT;
            decoded_q.push_back('{kind: KIND_ESC_ABORT, data: 8'h00, index: 9'd0,
                                  last: 1'b0, crc_ok: 1'b0});
            return;
         end
      end else if (b == FRAME_ESC) begin
         esc_armed = 1'b1;
         return;
      end else begin
         d = b;
      end
      // The two leading bytes carry the received CRC, high byte first, silently.
      if (body_cnt < 2) begin
         if (body_cnt == 0) begin
            rx_crc[15:8] = d;
         end else begin
            rx_crc[7:0] = d;
         end
         body_cnt++;
         return;
      end
      idx = body_cnt - 2;
      body_cnt++;
      calc_crc = crc16_xmodem_byte(calc_crc, d);
      fin = 1'b0;
      if (rx_mode == MODE_HEADER) begin
         if (idx == LEN_POS) begin
            pay_len = d;
         end
         // A zero length ends the message on the last header byte.
         if (idx >= HDR_BYTES - 1) begin
            if (pay_len == 8'h00) begin
               fin = 1'b1;
            end else begin
               rx_mode = MODE_PAYLOAD;
            end
         end
      end else if (idx >= HDR_BYTES + pay_len - 1) begin
         fin = 1'b1;
      end
      // Completion takes effect on the completing byte.
      if (fin) begin
         rx_mode = MODE_WAIT;
      end
      decoded_q.push_back('{kind: KIND_MSG, data: d, index: idx[8:0], last: fin,
                            crc_ok: fin && (calc_crc == rx_crc)});
   endtask

   // Random line byte, biased toward the framing codes and the extremes.
   function automatic logic [7:0] rand_line_byte();
      case ($urandom_range(15))
         0:       return FRAME_START;
         1:       return FRAME_ESC;
         2:       return ESC_FOR_START;
         3:       return ESC_FOR_ESC;
         4:       return 8'h00;
         5:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly short payloads, an empty one now and then.
   function automatic int pick_len();
      if ($urandom_range(7) == 0) begin
         return 0;
      end
      return $urandom_range(24, 1);
   endfunction

   // Append one byte to the line, escaping the two framing codes.
   task automatic put_escaped(input logic [7:0] b);
      if (b == FRAME_START) begin
         line_q.push_back(FRAME_ESC);
         line_q.push_back(ESC_FOR_START);
      end else if (b == FRAME_ESC) begin
         line_q.push_back(FRAME_ESC);
         line_q.push_back(ESC_FOR_ESC);
      end else begin
         line_q.push_back(b);
      end
   endtask

   // Append one frame: start, CRC, header, payload. A cut keeps only the first
   // cut_at body bytes and then appends the given tail.
   task automatic build_frame(input int plen, input bit bad_crc, input int cut_at,
                              input tail_kind_type tail);
      logic [7:0]  body[$];
      logic [15:0] crc;
      logic [7:0]  junk;
      int          n;
      crc = 16'h0000;
      for (int i = 0; i < HDR_BYTES; i++) begin
         body.push_back((i == LEN_POS) ? 8'(plen) : rand_line_byte());
      end
      for (int i = 0; i < plen; i++) begin
         body.push_back(rand_line_byte());
      end
      foreach (body[i]) begin
         crc = crc16_xmodem_byte(crc, body[i]);
      end
      if (bad_crc) begin
         crc = crc ^ 16'($urandom_range(16'hFFFF, 1));
      end
      n = (cut_at < 0) ? body.size() : cut_at;
      line_q.push_back(FRAME_START);
      put_escaped(crc[15:8]);
      put_escaped(crc[7:0]);
      for (int i = 0; i < n; i++) begin
         put_escaped(body[i]);
      end
      case (tail)
         TAIL_BAD_ESC: begin
            // Any code but the two valid ones and the start byte, the escape byte included.
            do begin
               junk = rand_line_byte();
            end while (junk == ESC_FOR_START || junk == ESC_FOR_ESC || junk == FRAME_START);
            line_q.push_back(FRAME_ESC);
            line_q.push_back(junk);
         end
         TAIL_OPEN_ESC: begin
            line_q.push_back(FRAME_ESC);
         end
         default: begin
         end
      endcase
   endtask

   // Queue about budget line bytes: mostly clean frames with random content, the rest
   // bad CRCs, cut-off frames, bad escapes, pending escapes and idle noise.
   task automatic queue_traffic(input int budget, input bit with_max);
      int stop_at;
      int r;
      int plen;
      stop_at = line_q.size() + budget;
      // The longest payload reaches the highest byte index a frame can carry.
      if (with_max) begin
         build_frame(255, 1'b0, -1, TAIL_NONE);
      end
      while (line_q.size() < stop_at) begin
         r    = $urandom_range(99);
         plen = pick_len();
         if (r < 62) begin
            build_frame(plen, 1'b0, -1, TAIL_NONE);
         end else if (r < 70) begin
            build_frame(plen, 1'b1, -1, TAIL_NONE);
         end else if (r < 80) begin
            build_frame(plen, 1'($urandom_range(1)), $urandom_range(HDR_BYTES + plen - 1),
                        TAIL_NONE);
         end else if (r < 88) begin
            build_frame(plen, 1'b0, $urandom_range(HDR_BYTES + plen - 1), TAIL_BAD_ESC);
         end else if (r < 95) begin
            repeat ($urandom_range(5, 1)) begin
               line_q.push_back(rand_line_byte());
            end
         end else begin
            build_frame(plen, 1'b0, $urandom_range(HDR_BYTES + plen - 1), TAIL_OPEN_ESC);
         end
      end
   endtask

   // Hold until the driver has handed every queued byte to the block.
   task automatic drain_line();
      while (line_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Driver: offer the oldest queued byte, keep it stable until taken, idle at random.
   always @(negedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!(drv_valid && !req_taken)) begin
         if (line_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drv_valid <= 1'b1;
            drv_byte  <= line_q[0];
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off when armed.
   always @(negedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
      end else if (hold_left != 0) begin
         sink_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         sink_ready <= 1'b0;
         hold_left = LONG_HOLD;
         hold_done = 1'b1;
      end else begin
         sink_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on every accepted line byte, check every accepted decoded
   // item against the oldest prediction, and watch for a stuck block.
   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      bit          req_fire;
      bit          rsp_fire;
      req_fire  = !reset && (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
      rsp_fire  = !reset && (rsp_ch.valid === 1'b1) && (rsp_ch.ready === 1'b1);
      req_taken = req_fire;
      if (req_fire) begin
         void'(line_q.pop_front());
         deframe_byte(req_ch.rx_byte);
      end
      if (rsp_fire) begin
         got = '{kind: kind_type'(rsp_ch.result_kind), data: rsp_ch.data_byte,
                 index: rsp_ch.byte_index, last: rsp_ch.last_byte, crc_ok: rsp_ch.crc_ok};
         if (decoded_q.size() == 0) begin
            mismatch_cnt++;
            $display({"%0t: expected no item,",
                      " got kind=%0d data=%02h idx=%0d last=%b ok=%b"},
                     $time, got.kind, got.data, got.index, got.last, got.crc_ok);
         end else begin
            want = decoded_q.pop_front();
            if (got.kind !== want.kind || got.data !== want.data
                || got.index !== want.index || got.last !== want.last
                || got.crc_ok !== want.crc_ok) begin
               mismatch_cnt++;
               $display({"%0t: expected kind=%0d data=%02h idx=%0d last=%b ok=%b,",
                         " got kind=%0d data=%02h idx=%0d last=%b ok=%b"},
                        $time, want.kind, want.data, want.index, want.last,
                        want.crc_ok, got.kind, got.data, got.index, got.last,
                        got.crc_ok);
            end
         end
      end
      // Count cycles in which no item moves on either side.
      if (req_fire || rsp_fire || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d items outstanding, %0d bytes unsent",
                  $time, quiet_cycles, decoded_q.size(), line_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Sequence: reset, directed cases, then three pacing phases of random frames.
   initial begin
      send_idle_pct = 23;
      recv_idle_pct = 69;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle noise at both extremes and an escape byte while waiting.
      line_q.push_back(8'h00);
      line_q.push_back(8'hFF);
      line_q.push_back(FRAME_ESC);
      // Start, then a start inside the frame.
      line_q.push_back(FRAME_START);
      line_q.push_back(FRAME_START);
      // A start byte clears a pending escape.
      line_q.push_back(FRAME_ESC);
      line_q.push_back(FRAME_START);
      // Bad escape code aborts to waiting.
      line_q.push_back(FRAME_ESC);
      line_q.push_back(8'h55);
      // Zero payload length: the message ends on the last header byte.
      build_frame(0, 1'b0, -1, TAIL_NONE);

      // Phase one: sender idles lightly, receiver heavily; one long hold-off
      // while the sender keeps offering, so the block backs up and stalls its input.
      queue_traffic(650, 1'b1);
      hold_arm = 1'b1;
      drain_line();

      // Phase two: the other way round, with a sender pause halfway until
      // every expected item has come back.
      send_idle_pct = 69;
      recv_idle_pct = 23;
      queue_traffic(325, 1'b0);
      drain_line();
      while (decoded_q.size() != 0) begin
         @(posedge clock);
      end
      queue_traffic(325, 1'b0);
      drain_line();

      // Phase three: neither side idles.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_traffic(650, 1'b1);
      drain_line();

      // Wait for the last expected item, then let the pipeline settle to catch strays.
      while (decoded_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ escaped_frame_receiver_crc16.f @@
+incdir+rtl/core
rtl/core/efr_pkg.sv
rtl/core/efr_channels.sv
rtl/core/efr_deframer.sv
rtl/core/escaped_frame_receiver_crc16.sv
rtl/core/efr_checker.sv
dv/tb_top.sv
